@@ sv/fat_directory_entry_parser_core_assert.svh @@
// Assertion macros shared by the directory entry parser RTL.
// Checks are compiled out when SYNTHESIS is defined; clock is clk_i, reset is rst_ni.
`ifndef FAT_DIRECTORY_ENTRY_PARSER_CORE_ASSERT_SVH
`define FAT_DIRECTORY_ENTRY_PARSER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define FDEP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define FDEP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define FDEP_ASSERT(lbl, prop, msg)
`define FDEP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ sv/fdep_pkg.sv @@
// Types and constants for the FAT directory entry parser.
// No dependencies; used by every module of the block.
package fdep_pkg;

  localparam int unsigned SlotBytes       = 32;
  localparam int unsigned PosW            = 5;
  localparam int unsigned SlotIdxW        = 10;
  localparam int unsigned MaxSlotsDefault = 1024;

  localparam logic [7:0] ByteDeleted  = 8'hE5;
  localparam logic [7:0] AttrLongName = 8'h0F;
  localparam logic [7:0] ByteEnd      = 8'h00;
  localparam logic [7:0] ByteSpace    = 8'h20;

  typedef logic [SlotBytes-1:0][7:0] slot_bytes_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       region_start;
  } in_beat_t;

  typedef struct packed {
    logic [63:0]         entry_name;
    logic [23:0]         entry_extension;
    logic [7:0]          attribute_bits;
    logic [15:0]         create_time;
    logic [15:0]         create_date;
    logic [15:0]         access_date;
    logic [15:0]         write_time;
    logic [15:0]         write_date;
    logic [15:0]         start_cluster;
    logic [31:0]         file_bytes;
    logic [SlotIdxW-1:0] slot_index;
    logic                end_marker;
  } out_beat_t;

  typedef struct packed {
    logic                emit;
    logic                end_mark;
    logic [SlotIdxW-1:0] slot_index;
  } asm_status_t;

endpackage

@@ sv/fat_directory_entry_parser_core.sv @@
// FAT directory entry parser. Takes one directory byte per beat, one beat per clock
// with no gaps needed while in_stall_o is low, and groups bytes into 32-byte slots.
// The beat that completes a slot (or the zero first byte that ends the directory)
// goes first into the input register, then its slot decode into the result
// register. Throughput is one byte per clock while out_stall_i is low, set by the
// single decode stage between those two registers. Deleted slots, and long-name
// slots while skip_q is set (its reset value), give no result; a new region is marked by region_start.
// Depends on fdep_pkg, fdep_assembler, fdep_decoder and the assertion header.
`include "fat_directory_entry_parser_core_assert.svh"

module fat_directory_entry_parser_core #(
  parameter int unsigned MaxSlots = fdep_pkg::MaxSlotsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fdep_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fdep_pkg::out_beat_t out_data_o
);

  logic                  skip_q;
  logic                  s1_valid_q, s1_valid_d;
  fdep_pkg::in_beat_t    s1_beat_q;
  logic                  out_valid_q, out_valid_d;
  fdep_pkg::out_beat_t   out_beat_q, result;
  logic                  advance, fire;
  fdep_pkg::slot_bytes_t slot_bytes;
  fdep_pkg::asm_status_t status;

  // result register can take a new value when empty or being drained
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;

  assign s1_valid_d  = in_stall_o ? s1_valid_q : in_valid_i;
  assign out_valid_d = advance ? (fire && status.emit) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q      <= 1'b1;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) skip_q <= cfg_data_i;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) s1_beat_q <= in_data_i;
    if (advance) out_beat_q <= result;
  end

  fdep_assembler #(
    .MaxSlots(MaxSlots)
  ) u_assembler (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .beat_i     (s1_beat_q),
    .skip_long_i(skip_q),
    .bytes_o    (slot_bytes),
    .status_o   (status)
  );

  fdep_decoder u_decoder (
    .bytes_i (slot_bytes),
    .status_i(status),
    .result_o(result)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_beat_q;

  `FDEP_ASSERT(a_stall_needs_beat, in_stall_o |-> s1_valid_q, "input stalled while empty")
  `FDEP_ASSERT(a_end_is_bare,
    out_valid_o && out_data_o.end_marker |->
      out_data_o.slot_index == '0 && out_data_o.file_bytes == '0,
    "end marker carries entry fields")
  `FDEP_ASSERT(a_stage_moves, fire |=> !$past(out_stall_i && out_valid_q),
    "beat advanced into a stalled result register")

endmodule

@@ sv/fdep_assembler.sv @@
// Slot assembler: byte position, slot counter, end-of-directory flag and slot byte store.
// Depends on fdep_pkg and fat_directory_entry_parser_core_assert.svh.
`include "fat_directory_entry_parser_core_assert.svh"

module fdep_assembler #(
  parameter int unsigned MaxSlots = fdep_pkg::MaxSlotsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  fdep_pkg::in_beat_t    beat_i,
  input  logic                  skip_long_i,
  output fdep_pkg::slot_bytes_t bytes_o,
  output fdep_pkg::asm_status_t status_o
);

  localparam int unsigned SlotW    = fdep_pkg::SlotIdxW;
  localparam int unsigned PosW     = fdep_pkg::PosW;
  localparam int unsigned SlotMaxW = (1 << SlotW) - 1;
  localparam int unsigned LimitRaw = MaxSlots - 1;
  localparam logic [SlotW-1:0] SlotLimit =
    SlotW'((LimitRaw > SlotMaxW) ? SlotMaxW : LimitRaw);
  localparam logic [PosW-1:0] LastPos = PosW'(fdep_pkg::SlotBytes - 1);

  logic [PosW-1:0]  pos_q, pos_d, pos_eff;
  logic [SlotW-1:0] slot_q, slot_d, slot_eff;
  logic             ended_q, ended_d, ended_eff;
  logic [7:0]       store_q [fdep_pkg::SlotBytes];
  logic             end_cond, write_en, last_byte;

  always_comb begin
    pos_eff   = beat_i.region_start ? '0 : pos_q;
    slot_eff  = beat_i.region_start ? '0 : slot_q;
    ended_eff = beat_i.region_start ? 1'b0 : ended_q;

    end_cond  = !ended_eff && (pos_eff == '0) && (beat_i.data_byte == fdep_pkg::ByteEnd);
    write_en  = fire_i && !ended_eff && !end_cond;
    last_byte = (pos_eff == LastPos);

    pos_d   = pos_q;
    slot_d  = slot_q;
    ended_d = ended_q;
    status_o = '0;
    if (fire_i) begin
      pos_d   = pos_eff;
      slot_d  = slot_eff;
      ended_d = ended_eff;
      if (end_cond) begin
        ended_d           = 1'b1;
        status_o.emit     = 1'b1;
        status_o.end_mark = 1'b1;
      end else if (!ended_eff) begin
        if (!last_byte) begin
          pos_d = pos_eff + PosW'(1);
        end else begin
          pos_d = '0;
          if (slot_eff < SlotLimit) slot_d = slot_eff + SlotW'(1);
          status_o.slot_index = slot_eff;
          // drop deleted slots, and long-name slots when asked to
          status_o.emit = (store_q[0] != fdep_pkg::ByteDeleted) &&
                          !(skip_long_i && (store_q[11] == fdep_pkg::AttrLongName));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      slot_q  <= '0;
      ended_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      slot_q  <= slot_d;
      ended_q <= ended_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (write_en) store_q[pos_eff] <= beat_i.data_byte;
  end

  // the last byte of a slot comes straight from the beat
  always_comb begin
    for (int k = 0; k < fdep_pkg::SlotBytes - 1; k++) bytes_o[k] = store_q[k];
    bytes_o[fdep_pkg::SlotBytes-1] = beat_i.data_byte;
  end

  `FDEP_ASSERT(a_ended_holds,
    ended_q && fire_i && !beat_i.region_start |=> $stable(pos_q) && $stable(slot_q),
    "state moved after end of directory")
  `FDEP_ASSERT(a_slot_limit, slot_q <= SlotLimit, "slot counter past its limit")
  `FDEP_ASSERT(a_emit_needs_fire, status_o.emit |-> fire_i, "result without a beat")

endmodule

@@ sv/fdep_decoder.sv @@
// Field decoder: turns one complete 32-byte slot, or an end mark, into a result beat.
// Depends on fdep_pkg only; purely combinational.
module fdep_decoder (
  input  fdep_pkg::slot_bytes_t bytes_i,
  input  fdep_pkg::asm_status_t status_i,
  output fdep_pkg::out_beat_t   result_o
);

  logic [63:0] name;
  logic [23:0] ext;
  logic [1:0]  ext_cnt;
  logic        stop;

  always_comb begin
    name = '0;
    stop = 1'b0;
    // cut the name at its first space
    for (int k = 0; k < 8; k++) begin
      if (bytes_i[k] == fdep_pkg::ByteSpace) stop = 1'b1;
      if (!stop) name[8*k +: 8] = bytes_i[k];
    end

    ext     = '0;
    ext_cnt = '0;
    // pack non-space extension bytes low first
    for (int k = 8; k < 11; k++) begin
      if (bytes_i[k] != fdep_pkg::ByteSpace) begin
        ext[{ext_cnt, 3'b000} +: 8] = bytes_i[k];
        ext_cnt = ext_cnt + 2'd1;
      end
    end
  end

  always_comb begin
    result_o = '0;
    if (status_i.end_mark) begin
      result_o.end_marker = 1'b1;
    end else begin
      result_o.entry_name      = name;
      result_o.entry_extension = ext;
      result_o.attribute_bits  = bytes_i[11];
      result_o.create_time     = {bytes_i[15], bytes_i[14]};
      result_o.create_date     = {bytes_i[17], bytes_i[16]};
      result_o.access_date     = {bytes_i[19], bytes_i[18]};
      result_o.write_time      = {bytes_i[23], bytes_i[22]};
      result_o.write_date      = {bytes_i[25], bytes_i[24]};
      result_o.start_cluster   = {bytes_i[27], bytes_i[26]};
      result_o.file_bytes      = {bytes_i[31], bytes_i[30], bytes_i[29], bytes_i[28]};
      result_o.slot_index      = status_i.slot_index;
    end
  end

endmodule
